/* src/exl_pkg.sv */
// Shared types, character codes and keyword table for the expression lexer.
`default_nettype none

package exl_pkg;

	localparam int MAX_WORD_DEF    = 6;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int KW_COUNT = 11;
	localparam int KW_MAX   = 6;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_STAR  = 8'h2a;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef enum logic [1:0] {
		RUN_IDLE = 2'd0,
		RUN_WORD = 2'd1,
		RUN_NUM  = 2'd2
	} run_mode_t;

	// first letter in byte 0
	typedef logic [KW_MAX-1:0][7:0] kw_text_t;

	localparam kw_text_t KW_TEXT [KW_COUNT] = '{
		{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h78},   // x
		{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h65},   // e
		{8'h00, 8'h00, 8'h00, 8'h00, 8'h69, 8'h70},   // pi
		{8'h00, 8'h00, 8'h00, 8'h6e, 8'h69, 8'h73},   // sin
		{8'h00, 8'h00, 8'h00, 8'h73, 8'h6f, 8'h63},   // cos
		{8'h00, 8'h00, 8'h00, 8'h70, 8'h78, 8'h65},   // exp
		{8'h00, 8'h00, 8'h00, 8'h00, 8'h6e, 8'h6c},   // ln
		{8'h00, 8'h00, 8'h00, 8'h00, 8'h67, 8'h6c},   // lg
		{8'h00, 8'h00, 8'h00, 8'h73, 8'h62, 8'h61},   // abs
		{8'h00, 8'h00, 8'h74, 8'h72, 8'h71, 8'h73},   // sqrt
		{8'h6e, 8'h61, 8'h74, 8'h63, 8'h72, 8'h61}    // arctan
	};

	localparam int KW_LEN [KW_COUNT] = '{1, 1, 2, 3, 3, 3, 2, 2, 3, 4, 6};

	// output steps of one request, in emission order
	typedef struct packed {
		logic pre_word;
		logic pre_sp;
		logic ch_en;
		logic ch_sp;
		logic post_word;
		logic post_sp;
		logic status;
	} act_t;

	typedef struct packed {
		act_t       act;
		logic       err;
		logic [7:0] ch;
	} cmd_t;

	localparam int CMD_W = $bits(cmd_t);

	function automatic logic is_op(input logic [7:0] c);
		return (c == CH_LPAR) || (c == CH_RPAR) || (c == CH_PLUS) || (c == CH_MINUS) ||
			(c == CH_STAR) || (c == CH_SLASH) || (c == CH_CARET);
	endfunction

endpackage

`default_nettype wire

/* src/exl_queue.sv */
// Small request queue between the classifier and the emitter.
`default_nettype none

module exl_queue
	import exl_pkg::*;
#(
	parameter int WIDTH = CMD_W,
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic [WIDTH-1:0]      rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign rdata   = mem_q[rptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (do_pop)
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wptr_q] <= wdata;
	end

endmodule

`default_nettype wire

/* src/exl_front.sv */
// Front end: takes characters, tracks word/number runs, checks keywords, issues requests.
`default_nettype none

module exl_front
	import exl_pkg::*;
#(
	parameter  int MAX_WORD = MAX_WORD_DEF,
	localparam int LEN_W    = $clog2(MAX_WORD + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [7:0]               char_code,
	input  wire logic                     end_of_text,
	input  wire logic                     q_full,
	output logic                          push,
	output cmd_t                          cmd,
	output logic [MAX_WORD-1:0][7:0]      word_letters,
	output logic [LEN_W-1:0]              word_len
);

	localparam int IDX_W = $clog2(MAX_WORD);

	run_mode_t                mode_q, mode_w;
	logic [MAX_WORD-1:0][7:0] letters_q, letters_w;
	logic [LEN_W-1:0]         len_q, len_w;
	logic                     tl_q, tl_w;
	logic                     stop_q, stop_w;
	logic                     err_q, err_w;
	logic                     accept;
	logic                     is_letter, is_digit, is_nz;

	function automatic logic kw_hit(input logic [MAX_WORD-1:0][7:0] w,
			input logic [LEN_W-1:0] n, input logic tl);
		logic hit;
		logic m;
		hit = 1'b0;
		for (int k = 0; k < KW_COUNT; k++) begin
			m = (n == LEN_W'(KW_LEN[k]));
			for (int i = 0; i < KW_MAX; i++)
				if (i < KW_LEN[k] && w[i] != KW_TEXT[k][i])
					m = 1'b0;
			hit = hit | m;
		end
		return hit && !tl;
	endfunction

	assign in_stall  = q_full;
	assign accept    = in_valid && !in_stall;
	assign is_letter = (char_code >= CH_LO_A) && (char_code <= CH_LO_Z);
	assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
	assign is_nz     = (char_code >= CH_ONE) && (char_code <= CH_NINE);

	always_comb begin
		mode_w    = mode_q;
		letters_w = letters_q;
		len_w     = len_q;
		tl_w      = tl_q;
		stop_w    = stop_q;
		err_w     = err_q;
		cmd       = '0;
		cmd.ch    = char_code;

		if (!stop_q) begin
			if (mode_q == RUN_WORD && is_letter) begin
				if (len_q < LEN_W'(MAX_WORD)) begin
					letters_w[len_q[IDX_W-1:0]] = char_code;
					len_w = len_q + 1'b1;
				end else begin
					tl_w = 1'b1;
				end
			end else if (mode_q == RUN_NUM && is_digit) begin
				cmd.act.ch_en = 1'b1;
			end else begin
				// close the open run before handling this character
				if (mode_q == RUN_WORD) begin
					if (kw_hit(letters_q, len_q, tl_q)) begin
						cmd.act.pre_word = 1'b1;
					end else begin
						err_w  = 1'b1;
						stop_w = 1'b1;
					end
				end else if (mode_q == RUN_NUM) begin
					cmd.act.pre_sp = 1'b1;
				end
				mode_w = RUN_IDLE;
				len_w  = '0;
				tl_w   = 1'b0;

				if (!stop_w) begin
					if (char_code == CH_SPACE) begin
						// dropped
					end else if (is_letter) begin
						mode_w       = RUN_WORD;
						letters_w[0] = char_code;
						len_w        = LEN_W'(1);
					end else if (is_nz) begin
						mode_w        = RUN_NUM;
						cmd.act.ch_en = 1'b1;
					end else if (char_code == CH_SEMI) begin
						cmd.act.ch_en = 1'b1;
						stop_w        = 1'b1;
					end else if (is_op(char_code)) begin
						cmd.act.ch_en = 1'b1;
						cmd.act.ch_sp = 1'b1;
					end else begin
						err_w  = 1'b1;
						stop_w = 1'b1;
					end
				end
			end

			// end of text closes whatever run is still open
			if (end_of_text && !stop_w) begin
				if (mode_w == RUN_WORD) begin
					if (kw_hit(letters_w, len_w, tl_w)) begin
						cmd.act.post_word = 1'b1;
					end else begin
						err_w  = 1'b1;
						stop_w = 1'b1;
					end
				end else if (mode_w == RUN_NUM) begin
					cmd.act.post_sp = 1'b1;
				end
			end
		end

		if (end_of_text) begin
			cmd.act.status = 1'b1;
			cmd.err        = err_w;
		end

		word_letters = cmd.act.pre_word ? letters_q : letters_w;
		word_len     = cmd.act.pre_word ? len_q : len_w;
	end

	assign push = accept && (cmd.act != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= RUN_IDLE;
			len_q  <= '0;
			tl_q   <= 1'b0;
			stop_q <= 1'b0;
			err_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				mode_q <= RUN_IDLE;
				len_q  <= '0;
				tl_q   <= 1'b0;
				stop_q <= 1'b0;
				err_q  <= 1'b0;
			end else begin
				mode_q <= mode_w;
				len_q  <= len_w;
				tl_q   <= tl_w;
				stop_q <= stop_w;
				err_q  <= err_w;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			letters_q <= letters_w;
	end

endmodule

`default_nettype wire

/* src/exl_back.sv */
// Back end: expands each request into output characters, one per cycle while not stalled, behind an output register.
`default_nettype none

module exl_back
	import exl_pkg::*;
#(
	parameter  int MAX_WORD = MAX_WORD_DEF,
	localparam int LEN_W    = $clog2(MAX_WORD + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     q_valid,
	input  wire cmd_t                     q_cmd,
	input  wire logic [MAX_WORD-1:0][7:0] q_letters,
	input  wire logic [LEN_W-1:0]         q_len,
	output logic                          pop,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [7:0]                    out_char,
	output logic                          char_valid,
	output logic                          last,
	output logic                          lexical_error
);

	localparam int IDX_W = $clog2(MAX_WORD);

	logic                     cur_v_q;
	act_t                     act_q, act_n;
	logic                     err_q;
	logic [7:0]               ch_q;
	logic [MAX_WORD-1:0][7:0] letters_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         idx_q, idx_n;
	logic                     out_valid_q;
	logic [7:0]               e_char;
	logic                     e_status;
	logic                     can_emit, fire, done;

	assign can_emit = !out_valid_q || !out_stall;
	assign fire     = cur_v_q && can_emit;

	always_comb begin
		act_n    = act_q;
		idx_n    = idx_q;
		e_char   = CH_SPACE;
		e_status = 1'b0;
		if (act_q.pre_word || (!act_q.pre_sp && !act_q.ch_en && !act_q.ch_sp &&
				act_q.post_word)) begin
			if (idx_q == len_q) begin
				act_n.pre_word  = 1'b0;
				act_n.post_word = 1'b0;
				idx_n           = '0;
			end else begin
				e_char = letters_q[idx_q[IDX_W-1:0]];
				idx_n  = idx_q + 1'b1;
			end
		end else if (act_q.pre_sp) begin
			act_n.pre_sp = 1'b0;
		end else if (act_q.ch_en) begin
			e_char      = ch_q;
			act_n.ch_en = 1'b0;
		end else if (act_q.ch_sp) begin
			act_n.ch_sp = 1'b0;
		end else if (act_q.post_sp) begin
			act_n.post_sp = 1'b0;
		end else begin
			e_char       = CH_NUL;
			e_status     = 1'b1;
			act_n.status = 1'b0;
		end
	end

	assign done = (act_n == '0);
	assign pop  = q_valid && (!cur_v_q || (fire && done));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			act_q   <= '0;
			idx_q   <= '0;
		end else if (pop) begin
			cur_v_q <= 1'b1;
			act_q   <= q_cmd.act;
			idx_q   <= '0;
		end else if (fire) begin
			cur_v_q <= !done;
			act_q   <= act_n;
			idx_q   <= idx_n;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			err_q     <= q_cmd.err;
			ch_q      <= q_cmd.ch;
			letters_q <= q_letters;
			len_q     <= q_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_char      <= e_char;
			char_valid    <= !e_status;
			last          <= e_status;
			lexical_error <= e_status && err_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

/* src/expression_char_lexer_top.sv */
// Top level of the expression character lexer.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | into      | in_valid / in_stall | char_code, end_of_text
//  out     | out of    | out_valid/out_stall | out_char, char_valid, last, lexical_error
//
// A character is taken every cycle unless the request queue is full.
// Output runs at one item per cycle while out_stall is low; a request yields up to MAX_WORD + 4 items,
// which the emitter expands while the front end keeps taking characters into the queue.
// A request reaches the output through a queue entry, the emitter's request register and the output register.
// Reset clears run state, queue and the output valid flag; no clearing pass.
// out_stall holds the output register and backs up through the queue to in_stall.
`default_nettype none

module expression_char_lexer_top
	import exl_pkg::*;
#(
	parameter int MAX_WORD    = MAX_WORD_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_code,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_char,
	output logic            char_valid,
	output logic            last,
	output logic            lexical_error
);

	localparam int LEN_W = $clog2(MAX_WORD + 1);
	localparam int QW    = CMD_W + MAX_WORD * 8 + LEN_W;

	cmd_t                     f_cmd, q_cmd;
	logic [MAX_WORD-1:0][7:0] f_letters, q_letters;
	logic [LEN_W-1:0]         f_len, q_len;
	logic                     push, pop, q_full, q_valid;
	logic [QW-1:0]            q_wdata, q_rdata;

	exl_front #(.MAX_WORD(MAX_WORD)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.end_of_text  (end_of_text),
		.q_full       (q_full),
		.push         (push),
		.cmd          (f_cmd),
		.word_letters (f_letters),
		.word_len     (f_len)
	);

	assign q_wdata = {f_cmd, f_letters, f_len};

	exl_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	assign {q_cmd, q_letters, q_len} = q_rdata;

	exl_back #(.MAX_WORD(MAX_WORD)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_cmd         (q_cmd),
		.q_letters     (q_letters),
		.q_len         (q_len),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_char      (out_char),
		.char_valid    (char_valid),
		.last          (last),
		.lexical_error (lexical_error)
	);

endmodule

`default_nettype wire

/* src/exl_checker.sv */
// Port-level checks on the lexer output stream, bound to the top level.
`default_nettype none

module exl_checker
	import exl_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_char,
	input wire logic       char_valid,
	input wire logic       last,
	input wire logic       lexical_error
);

	logic prev_space_q;

	// last delivered item was a space character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prev_space_q <= 1'b0;
		else if (out_valid && !out_stall)
			prev_space_q <= char_valid && (out_char == CH_SPACE);
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
		else $error("output request changed while stalled");

	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> !char_valid && (out_char == CH_NUL))
		else $error("status item carries a character");

	a_char_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> char_valid && !lexical_error && (out_char != CH_NUL))
		else $error("malformed character item");

	a_no_double_space: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && char_valid && prev_space_q |-> out_char != CH_SPACE)
		else $error("two separator spaces in a row");

endmodule

bind expression_char_lexer_top exl_checker u_exl_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.out_char      (out_char),
	.char_valid    (char_valid),
	.last          (last),
	.lexical_error (lexical_error)
);

`default_nettype wire

/* verif/expression_char_lexer_top_tb.sv */
// Self-checking testbench for the expression character lexer top level.
`timescale 1ns / 1ps

module expression_char_lexer_top_tb;
	import exl_pkg::*;

	localparam int MAX_WORD     = MAX_WORD_DEF;
	localparam int KW_NUM       = 11;
	localparam int IDLE_PCT     = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_LIMIT   = 2000;

	typedef struct packed {
		logic [7:0] ch;
		logic       cv;
		logic       lst;
		logic       err;
	} lex_item_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_code;
	logic       end_of_text;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_char;
	logic       char_valid;
	logic       last;
	logic       lexical_error;

	string      kw_names [KW_NUM] = '{"x", "e", "pi", "sin", "cos", "exp", "ln", "lg",
		"abs", "sqrt", "arctan"};
	logic [7:0] op_chars [7] = '{CH_LPAR, CH_RPAR, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
		CH_CARET};

	// predictor state
	run_mode_t  lex_mode;
	logic [7:0] word_buf [MAX_WORD];
	int         word_len;
	bit         too_long;
	bit         stopped;
	bit         err_seen;

	lex_item_t  spaced_text_q [$];
	logic [7:0] text_q [$];
	int         fails = 0;
	int         chars_sent = 0;
	int         quiet_cycles = 0;
	int         hold_left = 0;
	bit         full_rate = 0;

	expression_char_lexer_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.char_code     (char_code),
		.end_of_text   (end_of_text),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_char      (out_char),
		.char_valid    (char_valid),
		.last          (last),
		.lexical_error (lexical_error)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic bit is_letter(input logic [7:0] c);
		return (c >= CH_LO_A) && (c <= CH_LO_Z);
	endfunction

	function automatic bit is_operator(input logic [7:0] c);
		bit hit;
		hit = 0;
		foreach (op_chars[i])
			if (op_chars[i] == c)
				hit = 1;
		return hit;
	endfunction

	function automatic void add_expected(input lex_item_t it);
		spaced_text_q.insert(spaced_text_q.size(), it);
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		text_q.insert(text_q.size(), b);
	endfunction

	function automatic void push_char(input logic [7:0] c);
		add_expected('{c, 1'b1, 1'b0, 1'b0});
	endfunction

	function automatic void clear_lexer();
		lex_mode = RUN_IDLE;
		word_len = 0;
		too_long = 0;
		stopped  = 0;
		err_seen = 0;
	endfunction

	function automatic bit word_is_kw();
		bit hit;
		if (too_long)
			return 0;
		for (int k = 0; k < KW_NUM; k++) begin
			if (kw_names[k].len() != word_len)
				continue;
			hit = 1;
			for (int i = 0; i < word_len; i++)
				if (word_buf[i] != kw_names[k][i])
					hit = 0;
			if (hit)
				return 1;
		end
		return 0;
	endfunction

	function automatic void close_run();
		if (lex_mode == RUN_WORD) begin
			if (word_is_kw()) begin
				for (int i = 0; i < word_len; i++)
					push_char(word_buf[i]);
				push_char(CH_SPACE);
			end else begin
				err_seen = 1;
				stopped  = 1;
			end
		end else if (lex_mode == RUN_NUM) begin
			push_char(CH_SPACE);
		end
		lex_mode = RUN_IDLE;
		word_len = 0;
		too_long = 0;
	endfunction

	function automatic void put_letter(input logic [7:0] c);
		if (word_len < MAX_WORD) begin
			word_buf[word_len] = c;
			word_len++;
		end else begin
			too_long = 1;
		end
	endfunction

	function automatic void start_lexeme(input logic [7:0] c);
		if (c == CH_SPACE)
			return;
		if (is_letter(c)) begin
			lex_mode = RUN_WORD;
			word_len = 0;
			too_long = 0;
			put_letter(c);
		end else if (c >= CH_ONE && c <= CH_NINE) begin
			lex_mode = RUN_NUM;
			push_char(c);
		end else if (c == CH_SEMI) begin
			push_char(c);
			stopped = 1;
		end else if (is_operator(c)) begin
			push_char(c);
			push_char(CH_SPACE);
		end else begin
			err_seen = 1;
			stopped  = 1;
		end
	endfunction

	function automatic void lex_predict(input logic [7:0] c, input logic eot);
		if (!stopped) begin
			if (lex_mode == RUN_WORD && is_letter(c)) begin
				put_letter(c);
			end else if (lex_mode == RUN_NUM && c >= CH_ZERO && c <= CH_NINE) begin
				push_char(c);
			end else begin
				if (lex_mode != RUN_IDLE)
					close_run();
				if (!stopped)
					start_lexeme(c);
			end
			// a run cut off by the end of the text is still closed and checked
			if (eot && !stopped && lex_mode != RUN_IDLE)
				close_run();
		end
		if (eot) begin
			add_expected('{CH_NUL, 1'b0, 1'b1, err_seen});
			clear_lexer();
		end
	endfunction

	// ---------------- drivers ----------------

	task automatic send_char(input logic [7:0] c, input logic eot);
		@(negedge clk);
		while (!full_rate && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		char_code   <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		lex_predict(c, eot);
		chars_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text_q.size(); i++)
			send_char(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// mostly well-formed expressions, some with a stray byte or an unknown word
	task automatic build_random_text();
		int n_tok;
		int pick;
		int n;
		n_tok = $urandom_range(2, 8);
		for (int t = 0; t < n_tok; t++) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				add_str(kw_names[$urandom_range(KW_NUM - 1)]);
				add_byte(CH_SPACE);
			end else if (pick < 55) begin
				add_byte(8'($urandom_range(CH_ONE, CH_NINE)));
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++)
					add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
				if ($urandom_range(1))
					add_byte(CH_SPACE);
			end else if (pick < 85) begin
				add_byte(op_chars[$urandom_range(6)]);
			end else begin
				add_byte(CH_SPACE);
			end
		end
		pick = $urandom_range(99);
		if (pick < 15) begin
			text_q.insert($urandom_range(text_q.size()), 8'($urandom_range(255)));
		end else if (pick < 22) begin
			n = $urandom_range(1, MAX_WORD + 3);
			for (int i = 0; i < n; i++)
				text_q.insert(0, 8'($urandom_range(CH_LO_A, CH_LO_Z)));
		end
		if ($urandom_range(99) < 40) begin
			add_byte(CH_SEMI);
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++)
				add_byte(8'($urandom_range(255)));
		end
	endtask

	task automatic run_random_texts(input int n_chars);
		int start;
		start = chars_sent;
		while (chars_sent - start < n_chars) begin
			build_random_text();
			send_text();
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_directed();
		// keyword cut by operator, number with trailing zero, stop then ignored letter
		add_str("(x*9)/-10;q");
		send_text();
		// unknown word cut by operator: error, rest ignored
		add_str("q+");
		send_text();
		// one letter too many for the buffer
		add_str("arctans");
		send_text();
		// leading zero
		add_str("0");
		send_text();
		add_byte(8'hff);
		add_byte(CH_NUL);
		send_text();
		// end marker on a space: status only
		add_str(" ");
		send_text();
		// longest keyword cut by a digit, number cut by the end
		add_str("arctan1");
		send_text();
	endtask

	task automatic test_random_texts();
		run_random_texts(100);
	endtask

	task automatic test_full_rate();
		full_rate = 1;
		run_random_texts(50);
		full_rate = 0;
	endtask

	// receiver holds off while requests keep coming, so the queue fills
	task automatic test_output_holdoff();
		hold_left = HOLD_CYCLES;
		run_random_texts(35);
	endtask

	// ---------------- receiver, checker, watchdog ----------------

	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= !full_rate && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		lex_item_t want;
		lex_item_t got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_char, char_valid, last, lexical_error};
			if (spaced_text_q.size() == 0) begin
				$display("%0t: unexpected item char %h valid %b last %b err %b", $time,
					got.ch, got.cv, got.lst, got.err);
				fails++;
			end else begin
				want = spaced_text_q[0];
				spaced_text_q.delete(0);
				if (got !== want) begin
					$display("%0t: mismatch expected char %h valid %b last %b err %b",
						$time, want.ch, want.cv, want.lst, want.err);
					$display("%0t:          actual   char %h valid %b last %b err %b",
						$time, got.ch, got.cv, got.lst, got.err);
					fails++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("%0t: no traffic for %0d cycles", $time, IDLE_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		char_code   = CH_NUL;
		end_of_text = 1'b0;
		out_stall   = 1'b0;
		clear_lexer();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_texts();
		test_full_rate();
		test_output_holdoff();

		@(negedge clk);
		in_valid <= 1'b0;
		while (spaced_text_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (spaced_text_q.size() != 0) begin
			$display("%0t: %0d items never arrived", $time, spaced_text_q.size());
			fails++;
		end
		if (fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
